// ===== src/fbpe_pkg.sv =====
// Shared types, codes and constants of the page framebuffer pixel engine.
package fbpe_pkg;

    // Default store geometry
    localparam int MAX_COLUMNS_DEF = 192;
    localparam int MAX_PAGES_DEF   = 8;

    // Byte index width: 255 * 15 + 255 fits in 12 bits
    localparam int IDX_W = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_HEIGHT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [1:0] ROTATION_RST    = 2'd0;
    localparam logic [7:0] DISP_WIDTH_RST  = 8'd192;
    localparam logic [6:0] DISP_HEIGHT_RST = 7'd64;
    localparam logic [7:0] BUF_WIDTH_RST   = 8'd192;
    localparam logic [6:0] BUF_HEIGHT_RST  = 7'd64;

    // Quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Input command codes (code 3 is unused)
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Pixel operations
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SET    = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_KEEP   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DRAWN   = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_READ    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    // Work the back end carries out for one job
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RMW   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_act;

    // Configuration register set
    typedef struct packed {
        logic [1:0] rotation;
        logic [7:0] disp_w;
        logic [6:0] disp_h;
        logic [7:0] buf_w;
        logic [6:0] buf_h;
    } t_cfg;

    // One classified job between front and back
    typedef struct packed {
        t_act             act;
        t_status          status;
        logic [IDX_W-1:0] addr;
        logic [2:0]       bit_sel;
        t_op              op;
    } t_job;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/fbpe_ram.sv =====
// Generic single-port RAM with registered read data.
module fbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fbpe_front.sv =====
// Front end: accepts commands, clips and turns coordinates, forms byte index.
module fbpe_front
    import fbpe_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_busy,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic signed [8:0] i_pixel_x,
    input  logic signed [8:0] i_pixel_y,
    input  logic [1:0]        i_colour_op,
    input  logic [7:0]        i_read_column,
    input  logic [2:0]        i_read_page,
    output logic              o_job_valid,
    output t_job              o_job,
    input  logic              i_job_ready
);

    localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;

    // Stage 1 registers
    logic        r_s1_valid;
    t_act        r_act;
    t_status     r_status;
    logic        r_draw;
    logic        r_ok;
    logic [7:0]  r_col;
    logic [3:0]  r_page;
    logic [2:0]  r_bit;
    t_op         r_op;

    // Stage 1 combinational
    logic              accept;
    logic              load;
    logic [7:0]        lw;
    logic [7:0]        lh;
    logic              log_ok;
    logic              phys_ok;
    logic signed [9:0] sx;
    logic signed [9:0] sy;
    logic signed [9:0] dws;
    logic signed [9:0] dhs;
    logic signed [9:0] px;
    logic signed [9:0] py;
    t_act              n_act;
    t_status           n_status;
    logic              n_draw;
    logic              n_ok;
    logic [7:0]        n_col;
    logic [3:0]        n_page;
    logic [2:0]        n_bit;

    // Stage 2 combinational
    logic [IDX_W-1:0]  idx;
    logic              in_store;
    logic              fit;
    logic              push;

    assign push    = r_s1_valid && i_job_ready;
    assign load    = !r_s1_valid || push;
    assign o_ready = !i_busy && load;
    assign accept  = i_valid && o_ready;

    // Logical bounds, sizes swapped for quarter and three-quarter turns
    always_comb begin
        lw = i_cfg.rotation[0] ? {1'b0, i_cfg.buf_h} : i_cfg.buf_w;
        lh = i_cfg.rotation[0] ? i_cfg.buf_w : {1'b0, i_cfg.buf_h};
        log_ok = !i_pixel_x[8] && (i_pixel_x[7:0] < lw)
              && !i_pixel_y[8] && (i_pixel_y[7:0] < lh);
    end

    // Turn mapping onto the physical panel
    always_comb begin
        sx  = {i_pixel_x[8], i_pixel_x};
        sy  = {i_pixel_y[8], i_pixel_y};
        dws = signed'({2'b00, i_cfg.disp_w});
        dhs = signed'({3'b000, i_cfg.disp_h});
        unique case (i_cfg.rotation)
            ROT_0: begin
                px = sx;
                py = sy;
            end
            ROT_90: begin
                px = dws - 10'sd1 - sy;
                py = sx;
            end
            ROT_180: begin
                px = dws - 10'sd1 - sx;
                py = dhs - 10'sd1 - sy;
            end
            ROT_270: begin
                px = sy;
                py = dhs - 10'sd1 - sx;
            end
            default: begin
                px = sx;
                py = sy;
            end
        endcase
        phys_ok = !px[9] && (px[8:0] < {1'b0, i_cfg.buf_w})
               && !py[9] && (py[8:0] < {2'b00, i_cfg.buf_h});
    end

    // Classify the command
    always_comb begin
        n_act    = ACT_NONE;
        n_status = ST_CLIPPED;
        n_draw   = 1'b0;
        n_ok     = 1'b0;
        n_col    = px[7:0];
        n_page   = py[6:3];
        n_bit    = py[2:0];
        unique case (t_cmd'(i_command))
            CMD_DRAW: begin
                n_act    = (t_op'(i_colour_op) == OP_KEEP) ? ACT_NONE : ACT_RMW;
                n_status = ST_DRAWN;
                n_draw   = 1'b1;
                n_ok     = log_ok && phys_ok;
            end
            CMD_READ: begin
                n_act    = ACT_READ;
                n_status = ST_READ;
                n_col    = i_read_column;
                n_page   = {1'b0, i_read_page};
                n_ok     = (i_read_column < i_cfg.buf_w)
                        && ({1'b0, i_read_page, 3'b000} < i_cfg.buf_h);
            end
            CMD_CLEAR: begin
                n_act    = ACT_CLEAR;
                n_status = ST_CLEARED;
            end
            default: begin
                n_act    = ACT_NONE;
                n_status = ST_CLIPPED;
            end
        endcase
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_act    <= n_act;
            r_status <= n_status;
            r_draw   <= n_draw;
            r_ok     <= n_ok;
            r_col    <= n_col;
            r_page   <= n_page;
            r_bit    <= n_bit;
            r_op     <= t_op'(i_colour_op);
        end
    end

    // Stage 2: byte index and store bound
    always_comb begin
        idx      = {4'b0000, i_cfg.buf_w} * {8'h00, r_page} + {4'b0000, r_col};
        in_store = {1'b0, idx} < (IDX_W + 1)'(STORE_BYTES);
        fit      = r_ok && in_store;
        o_job.addr    = idx;
        o_job.bit_sel = r_bit;
        o_job.op      = r_op;
        o_job.status  = (r_draw && !fit) ? ST_CLIPPED : r_status;
        o_job.act     = ((r_act == ACT_RMW || r_act == ACT_READ) && !fit) ? ACT_NONE
                                                                          : r_act;
    end

    assign o_job_valid = r_s1_valid;

endmodule

// ===== src/fbpe_queue.sv =====
// Short job queue between front and back ends.
module fbpe_queue
    import fbpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== src/fbpe_back.sv =====
// Back end: frame store, read-modify-write, clearing sweep and result register.
module fbpe_back
    import fbpe_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    output logic       o_busy,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status
);

    localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD_WAIT,
        S_RMW_WAIT,
        S_CLEAR
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_cnt;
    logic [AW-1:0]  r_addr;
    logic [2:0]     r_bit;
    t_op            r_op;
    logic           r_out_valid;
    logic [7:0]     r_out_data;
    t_status        r_out_status;

    logic           out_free;
    logic           pop;
    logic           sweep_last;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;
    logic [7:0]     mask;
    logic [7:0]     merged;

    assign out_free    = !r_out_valid || i_ready;
    assign pop         = (r_state == S_IDLE) && i_job_valid && out_free;
    assign o_job_ready = pop;
    assign sweep_last  = r_cnt == AW'(STORE_BYTES - 1);
    assign o_busy      = r_state == S_INIT;

    // Bit update of the fetched byte
    always_comb begin
        mask = 8'h01 << r_bit;
        unique case (r_op)
            OP_CLEAR:  merged = ram_rdata & ~mask;
            OP_SET:    merged = ram_rdata | mask;
            OP_TOGGLE: merged = ram_rdata ^ mask;
            default:   merged = ram_rdata;
        endcase
    end

    // Store port control
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = i_job.addr[AW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_cnt;
            end
            S_RMW_WAIT: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = merged;
            end
            S_RD_WAIT: begin
                ram_addr = r_addr;
            end
            default: begin
                ram_addr = i_job.addr[AW-1:0];
            end
        endcase
    end

    fbpe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_addr <= i_job.addr[AW-1:0];
                        r_bit  <= i_job.bit_sel;
                        r_op   <= i_job.op;
                        unique case (i_job.act)
                            ACT_NONE: begin
                                r_out_valid  <= 1'b1;
                                r_out_data   <= '0;
                                r_out_status <= i_job.status;
                            end
                            ACT_RMW:   r_state <= S_RMW_WAIT;
                            ACT_READ:  r_state <= S_RD_WAIT;
                            ACT_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= ram_rdata;
                    r_out_status <= ST_READ;
                    r_state      <= S_IDLE;
                end
                S_RMW_WAIT: begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= '0;
                    r_out_status <= ST_DRAWN;
                    r_state      <= S_IDLE;
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (sweep_last) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= '0;
                        r_out_status <= ST_CLEARED;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;

endmodule

// ===== src/page_framebuffer_pixel_engine_unit.sv =====
// Page framebuffer pixel engine: top level with configuration registers.
//
// Input channel (i_valid/o_ready) takes one command per beat: draw pixel,
// read byte or clear store. Output channel (o_valid/i_ready) returns one
// result beat per command, in order: o_read_data and o_status.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while no command is in flight; the block does not enforce this.
// A draw or read that reaches the store holds the back end until its store
// access is done, a read-modify-write of one byte on the single store port
// for a draw; a clear holds the back end while it writes zero to each byte.
// A command that touches no store byte needs only a free result register.
// Reset: registers take their default values and the store is swept to
// zero, all MAX_COLUMNS*MAX_PAGES bytes (1536 by default), with o_ready low.
// A stalled receiver holds the result register; the two-entry job queue
// and the front stage keep taking beats until they fill.
module page_framebuffer_pixel_engine_unit
    import fbpe_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_command,
    input  logic signed [8:0]     i_pixel_x,
    input  logic signed [8:0]     i_pixel_y,
    input  logic [1:0]            i_colour_op,
    input  logic [7:0]            i_read_column,
    input  logic [2:0]            i_read_page,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_read_data,
    output logic [1:0]            o_status
);

    t_cfg r_cfg;
    logic busy;
    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation <= ROTATION_RST;
            r_cfg.disp_w   <= DISP_WIDTH_RST;
            r_cfg.disp_h   <= DISP_HEIGHT_RST;
            r_cfg.buf_w    <= BUF_WIDTH_RST;
            r_cfg.buf_h    <= BUF_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROTATION:    r_cfg.rotation <= i_cfg_data[1:0];
                CFG_DISP_WIDTH:  r_cfg.disp_w   <= i_cfg_data;
                CFG_DISP_HEIGHT: r_cfg.disp_h   <= i_cfg_data[6:0];
                CFG_BUF_WIDTH:   r_cfg.buf_w    <= i_cfg_data;
                CFG_BUF_HEIGHT:  r_cfg.buf_h    <= i_cfg_data[6:0];
                default:         r_cfg          <= r_cfg;
            endcase
        end
    end

    fbpe_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_busy        (busy),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_colour_op   (i_colour_op),
        .i_read_column (i_read_column),
        .i_read_page   (i_read_page),
        .o_job_valid   (fq_valid),
        .o_job         (fq_job),
        .i_job_ready   (fq_ready)
    );

    fbpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_job   (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_job   (qb_job)
    );

    fbpe_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (busy),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

endmodule

// ===== src/fbpe_checker.sv =====
// Port-level checker for the page framebuffer pixel engine, with its bind.
module fbpe_checker
    import fbpe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic [1:0] o_status
);

    // A result beat stays up until the receiver takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // Only reads carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_READ |-> o_read_data == 8'h00)
        else $error("nonzero data on a non-read result");

    // Store sweep after reset: no input taken
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input ready during reset sweep");

    // No result appears straight out of reset
    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind page_framebuffer_pixel_engine_unit fbpe_checker u_fbpe_checker (.*);
